/* rtl/archive_stream_unpacker_unit_macros.svh */
// ----------------------------------------------------------------------------
// Archive stream unpacker assertion macros
// Shared concurrent assertion forms for the unpacker RTL.
// ----------------------------------------------------------------------------
`ifndef ARCHIVE_STREAM_UNPACKER_UNIT_MACROS_SVH
`define ARCHIVE_STREAM_UNPACKER_UNIT_MACROS_SVH

// check cons in the same cycle as ante
`define ASU_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define ASU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/asu_pkg.sv */
// ----------------------------------------------------------------------------
// Archive stream unpacker package
// Request and result types, byte roles and field lengths.
// ----------------------------------------------------------------------------
package asu_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_last;
    } asu_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  byte_role;
        logic [31:0] entry_number;
        logic        entry_done;
        logic        stream_truncated;
    } asu_out_t;

    localparam logic [2:0] ROLE_COUNT = 3'd0;
    localparam logic [2:0] ROLE_PLEN  = 3'd1;
    localparam logic [2:0] ROLE_PATH  = 3'd2;
    localparam logic [2:0] ROLE_SIZE  = 3'd3;
    localparam logic [2:0] ROLE_DATA  = 3'd4;
    localparam logic [2:0] ROLE_TRAIL = 3'd5;

    localparam logic [3:0] HDR_BYTES  = 4'd4;
    localparam logic [3:0] PLEN_BYTES = 4'd2;
    localparam logic [3:0] SIZE_BYTES = 4'd8;

endpackage

/* rtl/asu_in_reg.sv */
// ----------------------------------------------------------------------------
// Archive stream unpacker input register
// Holds one request until the parser takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module asu_in_reg
    import asu_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  asu_in_t s_data,
    input  logic    take,
    output logic    item_valid,
    output asu_in_t item
);

    logic    valid_reg;
    logic    valid_next;
    asu_in_t data_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

/* rtl/asu_parser.sv */
// ----------------------------------------------------------------------------
// Archive stream unpacker parser
// Stream state and the per-byte tagging and counter update.
// ----------------------------------------------------------------------------
`include "archive_stream_unpacker_unit_macros.svh"

module asu_parser
    import asu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step_en,
    input  asu_in_t  item,
    output asu_out_t result
);

    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_PLEN  = 3'd1,
        PH_PATH  = 3'd2,
        PH_SIZE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_TRAIL = 3'd5
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [3:0]  fbc_reg,     fbc_next;
    logic [31:0] entries_reg, entries_next;
    logic [15:0] path_reg,    path_next;
    logic [63:0] data_reg,    data_next;
    logic [31:0] cur_reg,     cur_next;

    logic [3:0]  fbc_inc;
    logic [31:0] entries_dec;
    logic [15:0] path_dec;
    logic [63:0] data_dec;
    logic [2:0]  role;
    logic        done;
    logic        trunc;

    always_comb begin
        phase_next   = phase_reg;
        fbc_next     = fbc_reg;
        entries_next = entries_reg;
        path_next    = path_reg;
        data_next    = data_reg;
        cur_next     = cur_reg;
        fbc_inc      = fbc_reg + 4'd1;
        entries_dec  = entries_reg - 32'd1;
        path_dec     = path_reg - 16'd1;
        data_dec     = data_reg - 64'd1;
        role         = ROLE_TRAIL;
        done         = 1'b0;
        trunc        = 1'b0;

        unique case (phase_reg)
            PH_COUNT: begin
                role         = ROLE_COUNT;
                entries_next = {entries_reg[23:0], item.byte_value};
                fbc_next     = fbc_inc;
                if (fbc_inc >= HDR_BYTES) begin
                    fbc_next   = 4'd0;
                    phase_next = (entries_next != 32'd0) ? PH_PLEN : PH_TRAIL;
                end
            end
            PH_PLEN: begin
                role      = ROLE_PLEN;
                path_next = {path_reg[7:0], item.byte_value};
                fbc_next  = fbc_inc;
                if (fbc_inc >= PLEN_BYTES) begin
                    fbc_next   = 4'd0;
                    phase_next = (path_next != 16'd0) ? PH_PATH : PH_SIZE;
                end
            end
            PH_PATH: begin
                role      = ROLE_PATH;
                path_next = path_dec;
                if (path_dec == 16'd0) begin
                    phase_next = PH_SIZE;
                end
            end
            PH_SIZE: begin
                role      = ROLE_SIZE;
                data_next = {data_reg[55:0], item.byte_value};
                fbc_next  = fbc_inc;
                if (fbc_inc >= SIZE_BYTES) begin
                    fbc_next = 4'd0;
                    if (data_next != 64'd0) begin
                        phase_next = PH_DATA;
                    end else begin
                        done         = 1'b1;
                        entries_next = entries_dec;
                        cur_next     = cur_reg + 32'd1;
                        phase_next   = (entries_dec != 32'd0) ? PH_PLEN : PH_TRAIL;
                    end
                end
            end
            PH_DATA: begin
                role      = ROLE_DATA;
                data_next = data_dec;
                if (data_dec == 64'd0) begin
                    done         = 1'b1;
                    entries_next = entries_dec;
                    cur_next     = cur_reg + 32'd1;
                    phase_next   = (entries_dec != 32'd0) ? PH_PLEN : PH_TRAIL;
                end
            end
            PH_TRAIL: begin
                role = ROLE_TRAIL;
            end
            default: begin
                role = ROLE_TRAIL;
            end
        endcase

        if (item.is_last) begin
            // flag a header or entry left open, then restart the stream
            trunc = (phase_next == PH_COUNT) ||
                    (((phase_next == PH_PLEN) || (phase_next == PH_PATH) ||
                      (phase_next == PH_SIZE) || (phase_next == PH_DATA)) &&
                     !((phase_next == PH_PLEN) && (fbc_next == 4'd0)));
            phase_next   = PH_COUNT;
            fbc_next     = 4'd0;
            entries_next = 32'd0;
            path_next    = 16'd0;
            data_next    = 64'd0;
            cur_next     = 32'd0;
        end
    end

    assign result.out_byte         = item.byte_value;
    assign result.byte_role        = role;
    assign result.entry_number     = cur_reg;
    assign result.entry_done       = done;
    assign result.stream_truncated = trunc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_COUNT;
            fbc_reg     <= 4'd0;
            entries_reg <= 32'd0;
            path_reg    <= 16'd0;
            data_reg    <= 64'd0;
            cur_reg     <= 32'd0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            fbc_reg     <= fbc_next;
            entries_reg <= entries_next;
            path_reg    <= path_next;
            data_reg    <= data_next;
            cur_reg     <= cur_next;
        end
    end

    `ASU_ASSERT_SAME(a_done_role, aclk, aresetn, step_en && result.entry_done, (result.byte_role == ROLE_SIZE) || (result.byte_role == ROLE_DATA), "entry done outside size or data byte")
    `ASU_ASSERT_SAME(a_trunc_last, aclk, aresetn, step_en && result.stream_truncated, item.is_last, "truncation flagged before end of stream")
    `ASU_ASSERT_NEXT(a_last_restart, aclk, aresetn, step_en && item.is_last, (phase_reg == PH_COUNT) && (fbc_reg == 4'd0) && (entries_reg == 32'd0) && (cur_reg == 32'd0), "stream state not cleared after last byte")
    `ASU_ASSERT_SAME(a_trail_empty, aclk, aresetn, phase_reg == PH_TRAIL, entries_reg == 32'd0, "trailing phase with entries still declared")

endmodule

/* rtl/archive_stream_unpacker_unit.sv */
// ----------------------------------------------------------------------------
// Archive stream unpacker
// Byte-serial parser that tags each archive byte with role and entry number.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle and returns one tagged result per byte, in
// order. A byte passes through an input register, the parser updates its
// counters as the byte moves on, and the tagged result sits in an output
// register: an accepted request waits in the input register until the output
// register is free or being drained, and its result is then loaded into it.
// Sustained throughput is one byte per clock while results are taken, set by
// the counter update loop (the 64-bit data size decrement and zero compare). A
// result waiting at the output stalls the parser; the input register then
// takes one more request and s_ready drops until the result is taken.
module archive_stream_unpacker_unit
    import asu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  asu_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output asu_out_t m_data
);

    logic     item_valid;
    asu_in_t  item;
    logic     take;
    asu_out_t result;
    logic     m_valid_reg;
    logic     m_valid_next;
    asu_out_t m_data_reg;

    // advance when the output register is free or being drained
    assign take = item_valid && (!m_valid_reg || m_ready);

    asu_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    asu_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (take),
        .item    (item),
        .result  (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Archive stream unpacker testbench
// Feeds packed archive streams one byte per request through the unpacker and
// checks every tagged result against a parser model kept in the bench, with
// random idling on both sides, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module testbench;
    import asu_pkg::*;

    typedef struct {
        asu_in_t req;
        bit      drain_first;
    } stream_req_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    asu_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    asu_out_t m_data;

    stream_req_t req_queue[$];
    asu_out_t    tagged_expect[$];
    logic [7:0]  stream_bytes[$];

    logic [2:0]  prs_phase;
    logic [3:0]  prs_cnt;
    logic [31:0] prs_ents_left;
    logic [15:0] prs_path_left;
    logic [63:0] prs_data_left;
    logic [31:0] prs_entry;

    bit       req_taken = 1'b0;
    int       req_cnt   = 0;
    int       res_cnt   = 0;
    int       fail_cnt  = 0;
    int       done_cnt  = 0;
    int       trunc_cnt = 0;
    int       stall_left = 0;
    bit       stall_done = 1'b0;
    asu_out_t want_tag;

    archive_stream_unpacker_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_parser();
        prs_phase     = ROLE_COUNT;
        prs_cnt       = '0;
        prs_ents_left = '0;
        prs_path_left = '0;
        prs_data_left = '0;
        prs_entry     = '0;
    endfunction

    function automatic void close_entry();
        prs_ents_left = prs_ents_left - 32'd1;
        prs_entry     = prs_entry + 32'd1;
        prs_phase     = (prs_ents_left != 0) ? ROLE_PLEN : ROLE_TRAIL;
    endfunction

    function automatic void parse_byte(asu_in_t r);
        asu_out_t t;
        t.out_byte         = r.byte_value;
        t.byte_role        = prs_phase;
        t.entry_number     = prs_entry;
        t.entry_done       = 1'b0;
        t.stream_truncated = 1'b0;
        unique case (prs_phase)
            ROLE_COUNT: begin
                prs_ents_left = {prs_ents_left[23:0], r.byte_value};
                prs_cnt = prs_cnt + 4'd1;
                if (prs_cnt >= HDR_BYTES) begin
                    prs_cnt   = '0;
                    prs_phase = (prs_ents_left != 0) ? ROLE_PLEN : ROLE_TRAIL;
                end
            end
            ROLE_PLEN: begin
                prs_path_left = {prs_path_left[7:0], r.byte_value};
                prs_cnt = prs_cnt + 4'd1;
                if (prs_cnt >= PLEN_BYTES) begin
                    prs_cnt   = '0;
                    prs_phase = (prs_path_left != 0) ? ROLE_PATH : ROLE_SIZE;
                end
            end
            ROLE_PATH: begin
                prs_path_left = prs_path_left - 16'd1;
                if (prs_path_left == 0) prs_phase = ROLE_SIZE;
            end
            ROLE_SIZE: begin
                prs_data_left = {prs_data_left[55:0], r.byte_value};
                prs_cnt = prs_cnt + 4'd1;
                if (prs_cnt >= SIZE_BYTES) begin
                    prs_cnt = '0;
                    if (prs_data_left != 0) begin
                        prs_phase = ROLE_DATA;
                    end else begin
                        t.entry_done = 1'b1;
                        close_entry();
                    end
                end
            end
            ROLE_DATA: begin
                prs_data_left = prs_data_left - 64'd1;
                if (prs_data_left == 0) begin
                    t.entry_done = 1'b1;
                    close_entry();
                end
            end
            default: begin
                t.byte_role = ROLE_TRAIL;
            end
        endcase
        if (r.is_last) begin
            if (prs_phase == ROLE_COUNT)
                t.stream_truncated = 1'b1;
            else if (prs_phase >= ROLE_PLEN && prs_phase <= ROLE_DATA &&
                     !(prs_phase == ROLE_PLEN && prs_cnt == 0))
                t.stream_truncated = 1'b1;
            clear_parser();
        end
        tagged_expect.insert(tagged_expect.size(), t);
    endfunction

    function automatic void add_byte(logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endfunction

    function automatic void push_field(logic [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
    endfunction

    function automatic void queue_stream(bit drain);
        stream_req_t p;
        for (int i = 0; i < stream_bytes.size(); i++) begin
            p.req.byte_value = stream_bytes[i];
            p.req.is_last    = (i == stream_bytes.size() - 1);
            p.drain_first    = drain && (i == 0);
            req_queue.insert(req_queue.size(), p);
        end
        stream_bytes.delete();
    endfunction

    function automatic void build_random_stream();
        int          n_built;
        int          cut;
        logic [31:0] declared;
        logic [15:0] name_size;
        logic [63:0] data_len;
        bit          broken;
        broken = 1'b0;
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        n_built  = $urandom_range(0, 3);
        declared = n_built;
        if ($urandom_range(0, 9) == 0)
            declared = $urandom;
        else if ($urandom_range(0, 9) == 0)
            declared = n_built + $urandom_range(1, 2);
        push_field(64'(declared), 4);
        for (int e = 0; e < n_built && !broken; e++) begin
            name_size = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
            if ($urandom_range(0, 24) == 0) begin
                name_size = 16'($urandom_range(7, 65535));
                broken    = 1'b1;
            end
            push_field(64'(name_size), 2);
            if (broken) begin
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat (name_size) add_byte(8'($urandom_range(0, 255)));
                data_len = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 5));
                if ($urandom_range(0, 24) == 0) begin
                    data_len = {$urandom, $urandom};
                    broken   = 1'b1;
                end
                push_field(data_len, 8);
                if (broken)
                    repeat ($urandom_range(0, 3))
                        add_byte(8'($urandom_range(0, 255)));
                else
                    repeat (data_len) add_byte(8'($urandom_range(0, 255)));
            end
        end
        if (!broken && declared == n_built)
            repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0 && stream_bytes.size() > 1) begin
            cut = $urandom_range(1, stream_bytes.size() - 1);
            while (stream_bytes.size() > cut) stream_bytes.delete(stream_bytes.size() - 1);
        end
    endfunction

    // request side
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            // hold until accepted
        end else if (req_queue.size() != 0 &&
                     !(req_queue[0].drain_first && tagged_expect.size() != 0) &&
                     ((req_cnt >= 300 && req_cnt < 420) || $urandom_range(0, 99) >= 33)) begin
            s_valid <= 1'b1;
            s_data  <= req_queue[0].req;
        end else begin
            s_valid <= 1'b0;
        end
        req_taken = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            parse_byte(s_data);
            req_queue.delete(0);
            req_taken = 1'b1;
            req_cnt++;
        end
    end

    // result side
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (!stall_done && res_cnt >= 150) begin
            stall_done = 1'b1;
            stall_left = 199;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (res_cnt >= 450 && res_cnt < 570) || $urandom_range(0, 99) >= 33;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            res_cnt++;
            if (m_data.entry_done) done_cnt++;
            if (m_data.stream_truncated) trunc_cnt++;
            if (tagged_expect.size() == 0) begin
                $error("result with nothing expected: %p", m_data);
                fail_cnt++;
            end else begin
                want_tag = tagged_expect.pop_front();
                if (m_data.out_byte !== want_tag.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want_tag.out_byte, m_data.out_byte);
                    fail_cnt++;
                end
                if (m_data.byte_role !== want_tag.byte_role) begin
                    $error("byte_role: expected %0d, got %0d",
                           want_tag.byte_role, m_data.byte_role);
                    fail_cnt++;
                end
                if (m_data.entry_number !== want_tag.entry_number) begin
                    $error("entry_number: expected %0d, got %0d",
                           want_tag.entry_number, m_data.entry_number);
                    fail_cnt++;
                end
                if (m_data.entry_done !== want_tag.entry_done) begin
                    $error("entry_done: expected %0b, got %0b",
                           want_tag.entry_done, m_data.entry_done);
                    fail_cnt++;
                end
                if (m_data.stream_truncated !== want_tag.stream_truncated) begin
                    $error("stream_truncated: expected %0b, got %0b",
                           want_tag.stream_truncated, m_data.stream_truncated);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int n_streams;
        n_streams = 0;
        clear_parser();

        // one entry with empty path and data, then a trailing byte
        push_field(64'd1, 4);
        push_field(64'd0, 2);
        push_field(64'd0, 8);
        add_byte(8'hFF);
        queue_stream(1'b0);
        // zero entries, trailing byte only
        push_field(64'd0, 4);
        add_byte(8'hA5);
        queue_stream(1'b0);
        // header cut short
        push_field(64'hFFFF, 2);
        queue_stream(1'b0);
        // stream of a single byte
        add_byte(8'h80);
        queue_stream(1'b0);

        while (req_queue.size() < 723) begin
            build_random_stream();
            n_streams++;
            queue_stream(n_streams % 5 == 4);
        end
        n_streams += 4;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        while (req_queue.size() != 0) @(posedge aclk);
        while (tagged_expect.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("tb: %0d byte requests in %0d streams, %0d tagged results checked",
                 req_cnt, n_streams, res_cnt);
        $display("tb: %0d entries completed, %0d truncated stream ends seen",
                 done_cnt, trunc_cnt);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
